// ===== rtl/ed4_pkg.sv =====
// ----------------------------------------------------------------------------
// ed4_pkg
// Shared types and constants for the 4-D Euclidean distance pipeline.
// ----------------------------------------------------------------------------
package ed4_pkg;

    localparam int NUM_DIMS       = 4;
    localparam int DIST_BITS      = 18;
    localparam int RAD_BITS       = 2 * DIST_BITS;
    localparam int REM_BITS       = DIST_BITS + 3;
    localparam int BITS_PER_STAGE = 2;
    localparam int SQRT_STAGES    = DIST_BITS / BITS_PER_STAGE;

    typedef struct packed {
        logic                 valid;
        logic [RAD_BITS-1:0]  rad;
        logic [REM_BITS-1:0]  rem;
        logic [DIST_BITS-1:0] root;
    } sqrt_pipe_t;

endpackage

// ===== rtl/euclidean_distance_4d_top.sv =====
// ----------------------------------------------------------------------------
// euclidean_distance_4d_top
// Floor of the Euclidean distance between two 4-D fixed-point points.
//
//   channel  | ports                                   | handshake
//   ---------+-----------------------------------------+---------------------
//   input    | first_w..z, second_w..z (COORD_BITS)    | start & !busy
//   result   | distance (18 bits, unsigned)            | done, one cycle
//
// Takes one transfer every cycle; busy stays low.
// The data passes through the difference and square stages, the adder tree
// and the square root stages, which resolve two root bits per stage.
// Reset clears only the valid bits of the stages.
// The receiver cannot stall; each result is shown once on done.
// ----------------------------------------------------------------------------
module euclidean_distance_4d_top #(
    parameter int COORD_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [COORD_BITS-1:0]         first_w,
    input  logic [COORD_BITS-1:0]         first_x,
    input  logic [COORD_BITS-1:0]         first_y,
    input  logic [COORD_BITS-1:0]         first_z,
    input  logic [COORD_BITS-1:0]         second_w,
    input  logic [COORD_BITS-1:0]         second_x,
    input  logic [COORD_BITS-1:0]         second_y,
    input  logic [COORD_BITS-1:0]         second_z,
    output logic                          done,
    output logic [ed4_pkg::DIST_BITS-1:0] distance
);
    import ed4_pkg::*;

    logic [COORD_BITS-1:0]   first_pt  [NUM_DIMS];
    logic [COORD_BITS-1:0]   second_pt [NUM_DIMS];
    logic                    sq_valid;
    logic [2*COORD_BITS+1:0] sq        [NUM_DIMS];
    sqrt_pipe_t              pipe      [SQRT_STAGES+1];

    assign busy = 1'b0;

    assign first_pt[0]  = first_w;
    assign first_pt[1]  = first_x;
    assign first_pt[2]  = first_y;
    assign first_pt[3]  = first_z;
    assign second_pt[0] = second_w;
    assign second_pt[1] = second_x;
    assign second_pt[2] = second_y;
    assign second_pt[3] = second_z;

    ed4_diff_sq #(
        .COORD_BITS (COORD_BITS)
    ) u_diff_sq (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (start),
        .first_pt  (first_pt),
        .second_pt (second_pt),
        .valid_out (sq_valid),
        .sq_out    (sq)
    );

    ed4_sum #(
        .COORD_BITS (COORD_BITS)
    ) u_sum (
        .clk      (clk),
        .rst_n    (rst_n),
        .valid_in (sq_valid),
        .sq_in    (sq),
        .pipe_out (pipe[0])
    );

    generate
        for (genvar s = 0; s < SQRT_STAGES; s++)
        begin : g_sqrt
            ed4_sqrt_stage u_stage (
                .clk      (clk),
                .rst_n    (rst_n),
                .pipe_in  (pipe[s]),
                .pipe_out (pipe[s+1])
            );
        end
    endgenerate

    assign done     = pipe[SQRT_STAGES].valid;
    assign distance = pipe[SQRT_STAGES].root;

endmodule

// ===== rtl/ed4_diff_sq.sv =====
// ----------------------------------------------------------------------------
// ed4_diff_sq
// Per-axis difference, magnitude and square, three register stages.
// ----------------------------------------------------------------------------
module ed4_diff_sq #(
    parameter int COORD_BITS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        valid_in,
    input  logic [COORD_BITS-1:0]       first_pt  [ed4_pkg::NUM_DIMS],
    input  logic [COORD_BITS-1:0]       second_pt [ed4_pkg::NUM_DIMS],
    output logic                        valid_out,
    output logic [2*COORD_BITS+1:0]     sq_out    [ed4_pkg::NUM_DIMS]
);
    import ed4_pkg::*;

    localparam int DIFF_W = COORD_BITS + 1;
    localparam int SQ_W   = 2 * DIFF_W;

    logic [2:0]        valid_reg;
    logic [2:0]        valid_next;
    logic [DIFF_W-1:0] diff_reg  [NUM_DIMS];
    logic [DIFF_W-1:0] diff_next [NUM_DIMS];
    logic [DIFF_W-1:0] mag_reg   [NUM_DIMS];
    logic [DIFF_W-1:0] mag_next  [NUM_DIMS];
    logic [SQ_W-1:0]   sq_reg    [NUM_DIMS];
    logic [SQ_W-1:0]   sq_next   [NUM_DIMS];

    assign valid_next = {valid_reg[1:0], valid_in};

    always_comb
    begin
        for (int d = 0; d < NUM_DIMS; d++)
        begin
            diff_next[d] = {second_pt[d][COORD_BITS-1], second_pt[d]}
                         - {first_pt[d][COORD_BITS-1], first_pt[d]};
            mag_next[d]  = diff_reg[d][DIFF_W-1] ? (~diff_reg[d] + 1'b1) : diff_reg[d];
            sq_next[d]   = mag_reg[d] * mag_reg[d];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        diff_reg <= diff_next;
        mag_reg  <= mag_next;
        sq_reg   <= sq_next;
    end

    assign valid_out = valid_reg[2];
    assign sq_out    = sq_reg;

endmodule

// ===== rtl/ed4_sum.sv =====
// ----------------------------------------------------------------------------
// ed4_sum
// Adder tree over the four squares, clamped to the root radicand width if wider.
// ----------------------------------------------------------------------------
module ed4_sum #(
    parameter int COORD_BITS = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    valid_in,
    input  logic [2*COORD_BITS+1:0] sq_in [ed4_pkg::NUM_DIMS],
    output ed4_pkg::sqrt_pipe_t     pipe_out
);
    import ed4_pkg::*;

    localparam int SQ_W   = 2 * (COORD_BITS + 1);
    localparam int PAIR_W = SQ_W + 1;
    localparam int SUM_W  = SQ_W + 2;

    logic [1:0]          valid_reg;
    logic [1:0]          valid_next;
    logic [PAIR_W-1:0]   pair0_reg;
    logic [PAIR_W-1:0]   pair0_next;
    logic [PAIR_W-1:0]   pair1_reg;
    logic [PAIR_W-1:0]   pair1_next;
    logic [SUM_W-1:0]    total;
    logic [RAD_BITS-1:0] rad_reg;
    logic [RAD_BITS-1:0] rad_next;

    assign valid_next = {valid_reg[0], valid_in};
    assign pair0_next = {1'b0, sq_in[0]} + {1'b0, sq_in[1]};
    assign pair1_next = {1'b0, sq_in[2]} + {1'b0, sq_in[3]};
    assign total      = {1'b0, pair0_reg} + {1'b0, pair1_reg};

    // saturate: any sum at or above 2^RAD_BITS has the all-ones root
    generate
        if (SUM_W > RAD_BITS)
        begin : g_clamp
            assign rad_next = (|total[SUM_W-1:RAD_BITS]) ? '1 : total[RAD_BITS-1:0];
        end
        else
        begin : g_extend
            assign rad_next = RAD_BITS'(total);
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pair0_reg <= pair0_next;
        pair1_reg <= pair1_next;
        rad_reg   <= rad_next;
    end

    always_comb
    begin
        pipe_out.valid = valid_reg[1];
        pipe_out.rad   = rad_reg;
        pipe_out.rem   = '0;
        pipe_out.root  = '0;
    end

endmodule

// ===== rtl/ed4_sqrt_stage.sv =====
// ----------------------------------------------------------------------------
// ed4_sqrt_stage
// One registered step of the restoring square root, two root bits per stage.
// ----------------------------------------------------------------------------
module ed4_sqrt_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  ed4_pkg::sqrt_pipe_t pipe_in,
    output ed4_pkg::sqrt_pipe_t pipe_out
);
    import ed4_pkg::*;

    logic                 valid_reg;
    logic [RAD_BITS-1:0]  rad_reg;
    logic [RAD_BITS-1:0]  rad_next;
    logic [REM_BITS-1:0]  rem_reg;
    logic [REM_BITS-1:0]  rem_next;
    logic [DIST_BITS-1:0] root_reg;
    logic [DIST_BITS-1:0] root_next;

    always_comb
    begin
        logic [REM_BITS-1:0] trial;
        rad_next  = pipe_in.rad;
        rem_next  = pipe_in.rem;
        root_next = pipe_in.root;
        for (int i = 0; i < BITS_PER_STAGE; i++)
        begin
            // bring down the next radicand digit pair
            rem_next = {rem_next[REM_BITS-3:0], rad_next[RAD_BITS-1 -: 2]};
            rad_next = {rad_next[RAD_BITS-3:0], 2'b00};
            trial    = REM_BITS'({root_next, 2'b01});
            if (rem_next >= trial)
            begin
                rem_next  = rem_next - trial;
                root_next = {root_next[DIST_BITS-2:0], 1'b1};
            end
            else
            begin
                root_next = {root_next[DIST_BITS-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= pipe_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    always_comb
    begin
        pipe_out.valid = valid_reg;
        pipe_out.rad   = rad_reg;
        pipe_out.rem   = rem_reg;
        pipe_out.root  = root_reg;
    end

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Testbench for euclidean_distance_4d_top.
// Sends pairs of 4-D Q16.0 points to the distance pipeline: first a short
// directed set of corner cases, then random pairs with random sender gaps.
// Each distance is predicted in the testbench as the floor of the exact square
// root of the summed squared differences, and is checked in order against the
// results the block reports on done.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

    import ed4_pkg::*;

    localparam int COORD_BITS    = 16;
    localparam int RANDOM_PAIRS  = 880;
    localparam int CALM_TAIL     = 150;
    localparam int SETTLE_CYCLES = 24;
    localparam logic [COORD_BITS-1:0] COORD_MIN = 16'h8000;
    localparam logic [COORD_BITS-1:0] COORD_MAX = 16'h7FFF;
    localparam logic [COORD_BITS-1:0] COORD_ONE = 16'h0001;
    localparam logic [COORD_BITS-1:0] COORD_NEG = 16'hFFFF;

    typedef struct packed {
        logic [NUM_DIMS-1:0][COORD_BITS-1:0] first;
        logic [NUM_DIMS-1:0][COORD_BITS-1:0] second;
    } point_pair_t;

    logic clk;
    logic rst_n;
    logic start = 1'b0;
    logic busy;
    logic done;
    logic [DIST_BITS-1:0] distance;
    point_pair_t          driven_pair = '0;

    point_pair_t          pending_pairs[$];
    logic [DIST_BITS-1:0] expected_distances[$];

    int total_pairs;
    int directed_pairs;
    int transfers = 0;
    int distances_checked = 0;
    int mismatches = 0;
    int idle_left = 0;
    int idle_odds = 2;
    int drain_mark;
    bit drain_done = 1'b0;

    euclidean_distance_4d_top #(
        .COORD_BITS(COORD_BITS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .first_w  (driven_pair.first[0]),
        .first_x  (driven_pair.first[1]),
        .first_y  (driven_pair.first[2]),
        .first_z  (driven_pair.first[3]),
        .second_w (driven_pair.second[0]),
        .second_x (driven_pair.second[1]),
        .second_y (driven_pair.second[2]),
        .second_z (driven_pair.second[3]),
        .done     (done),
        .distance (distance)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic [DIST_BITS-1:0] floor_distance(point_pair_t pair);
        longint               sum_sq;
        longint               diff;
        logic [DIST_BITS-1:0] root;
        logic [DIST_BITS-1:0] trial;
        sum_sq = 0;
        for (int d = 0; d < NUM_DIMS; d++)
        begin
            diff = longint'($signed(pair.second[d])) - longint'($signed(pair.first[d]));
            sum_sq += diff * diff;
        end
        root = '0;
        for (int b = DIST_BITS - 1; b >= 0; b--)
        begin
            trial = root | (DIST_BITS'(1) << b);
            if (longint'(trial) * longint'(trial) <= sum_sq)
                root = trial;
        end
        return root;
    endfunction

    task automatic report_mismatch(string what);
        $display("ERROR at %0t ns: %s", $time, what);
        mismatches++;
    endtask

    task automatic queue_pair(
        logic [COORD_BITS-1:0] fw, logic [COORD_BITS-1:0] fx,
        logic [COORD_BITS-1:0] fy, logic [COORD_BITS-1:0] fz,
        logic [COORD_BITS-1:0] sw, logic [COORD_BITS-1:0] sx,
        logic [COORD_BITS-1:0] sy, logic [COORD_BITS-1:0] sz
    );
        point_pair_t pair;
        pair.first  = {fz, fy, fx, fw};
        pair.second = {sz, sy, sx, sw};
        pending_pairs.push_back(pair);
    endtask

    function automatic logic [COORD_BITS-1:0] corner_coord();
        case ($urandom_range(0, 6))
            0: return COORD_MIN;
            1: return COORD_MIN + COORD_ONE;
            2: return COORD_NEG;
            3: return '0;
            4: return COORD_ONE;
            5: return COORD_MAX - COORD_ONE;
            default: return COORD_MAX;
        endcase
    endfunction

    // driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            if (start && !busy)
            begin
                expected_distances.push_back(floor_distance(driven_pair));
                transfers++;
                if (transfers % 64 == 0)
                    idle_odds = $urandom_range(0, 3);
            end
            if (start && busy)
            begin
                // hold the current transfer until it is taken
            end
            else if (!drain_done && transfers == drain_mark)
            begin
                start <= 1'b0;
                if (expected_distances.size() == 0)
                    drain_done = 1'b1;
            end
            else if (idle_left > 0)
            begin
                idle_left--;
                start <= 1'b0;
            end
            else if (pending_pairs.size() > 0)
            begin
                driven_pair <= pending_pairs.pop_front();
                start <= 1'b1;
                if (transfers < total_pairs - CALM_TAIL && idle_odds != 0
                    && $urandom_range(1, 4) <= idle_odds)
                    idle_left = $urandom_range(1, 5);
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_distances.size() == 0)
            begin
                report_mismatch($sformatf("distance %0d with no transfer outstanding",
                                          distance));
            end
            else
            begin
                logic [DIST_BITS-1:0] want;
                want = expected_distances.pop_front();
                distances_checked++;
                if (distance !== want)
                    report_mismatch($sformatf("distance %0d, predicted %0d",
                                              distance, want));
            end
        end
    end

    initial
    begin
        #2400000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        logic [COORD_BITS-1:0] a;
        logic [COORD_BITS-1:0] b;
        point_pair_t           pair;
        rst_n             = 1'b0;

        queue_pair('0, '0, '0, '0, '0, '0, '0, '0);
        queue_pair(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
                   COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
        queue_pair(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                   COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN);
        queue_pair(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
                   COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN);
        queue_pair(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                   COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
        queue_pair(COORD_MIN, '0, '0, '0, COORD_MAX, '0, '0, '0);
        queue_pair('0, COORD_MIN, '0, '0, '0, COORD_MAX, '0, '0);
        queue_pair('0, '0, COORD_MAX, '0, '0, '0, COORD_MIN, '0);
        queue_pair('0, '0, '0, COORD_MAX, '0, '0, '0, COORD_MIN);
        queue_pair(COORD_NEG, '0, '0, '0, '0, '0, '0, '0);
        queue_pair('0, '0, '0, '0, COORD_ONE, COORD_ONE, COORD_ONE, COORD_ONE);
        queue_pair(COORD_NEG, COORD_NEG, COORD_NEG, COORD_NEG,
                   COORD_ONE, COORD_ONE, COORD_ONE, COORD_ONE);
        queue_pair(16'd3, '0, '0, '0, '0, 16'd4, '0, '0);
        queue_pair(COORD_MIN, COORD_MAX, COORD_NEG, COORD_ONE,
                   COORD_MAX, COORD_MIN, COORD_ONE, COORD_NEG);
        queue_pair(16'h5555, 16'hAAAA, 16'h0F0F, 16'hF0F0,
                   16'hAAAA, 16'h5555, 16'hF0F0, 16'h0F0F);
        queue_pair(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
                   '0, '0, '0, '0);
        directed_pairs = pending_pairs.size();

        for (int i = 0; i < RANDOM_PAIRS; i++)
        begin
            for (int d = 0; d < NUM_DIMS; d++)
            begin
                case ($urandom_range(0, 9))
                    0, 1:
                    begin
                        a = corner_coord();
                        b = corner_coord();
                    end
                    2, 3:
                    begin
                        a = COORD_BITS'($urandom);
                        b = a + COORD_BITS'($urandom_range(0, 64)) - 16'd32;
                    end
                    4:
                    begin
                        a = COORD_BITS'($urandom);
                        b = a;
                    end
                    default:
                    begin
                        a = COORD_BITS'($urandom);
                        b = COORD_BITS'($urandom);
                    end
                endcase
                pair.first[d]  = a;
                pair.second[d] = b;
            end
            pending_pairs.push_back(pair);
        end
        total_pairs = pending_pairs.size();
        drain_mark  = directed_pairs + RANDOM_PAIRS / 3;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        do
            @(posedge clk);
        while (pending_pairs.size() != 0 || start || expected_distances.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d point pairs (%0d directed corner cases, %0d random) and",
                 transfers, directed_pairs, transfers - directed_pairs);
        $display("checked %0d distances, with one full drain of the pipeline mid-run.",
                 distances_checked);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
